@@ rtl/core/imufp_pkg.sv @@
package imufp_pkg;

	localparam logic [7:0] HEAD0_BYTE = 8'hA5;
	localparam logic [7:0] HEAD1_BYTE = 8'h5A;
	localparam logic [7:0] TAIL_BYTE  = 8'hAA;

	localparam logic [5:0] POS_HEAD0     = 6'd0;
	localparam logic [5:0] POS_HEAD1     = 6'd1;
	localparam logic [5:0] POS_BODY_LAST = 6'd37;
	localparam logic [5:0] POS_CHECK     = 6'd38;
	localparam logic [5:0] POS_TAIL      = 6'd39;
	localparam logic [5:0] PAY_FIRST     = 6'd3;
	localparam logic [5:0] PAY_LAST      = 6'd20;

	localparam int PAY_COUNT = 18;
	localparam int PAY_IDX_W = $clog2(PAY_COUNT);
	localparam int NUM_WORDS = 9;

	localparam int ACCEL_SHIFT = 14;

	// floor(x/164) for x < 2^19: q_est = (x * RATE_RECIP) >> RATE_SHIFT is q or q-1
	localparam int RATE_X_W     = 19;
	localparam int RATE_Q_W     = 11;
	localparam int RATE_SHIFT   = 24;
	localparam int RATE_RECIP_W = 17;
	localparam int RATE_PROD_W  = RATE_X_W + RATE_RECIP_W;
	localparam logic [RATE_RECIP_W-1:0] RATE_RECIP = RATE_RECIP_W'((1 << RATE_SHIFT) / 164);
	localparam logic [RATE_X_W-1:0]     RATE_DEN   = RATE_X_W'(164);

	typedef struct packed {
		logic [NUM_WORDS-1:0][15:0] words;
	} frame_t;

	typedef struct packed {
		logic signed [15:0] yaw;
		logic signed [15:0] pitch;
		logic signed [15:0] roll;
		logic signed [2:0]  accel_x;
		logic signed [2:0]  accel_y;
		logic signed [2:0]  accel_z;
		logic signed [11:0] rate_x;
		logic signed [11:0] rate_y;
		logic signed [11:0] rate_z;
	} result_t;

	typedef struct packed {
		logic valid;
	} link_t;

endpackage

@@ rtl/core/imu_frame_parser.sv @@
// Channel   Direction  Handshake         Payload
// request   in         push / full       rx_byte
// result    out        pop / empty       yaw, pitch, roll, accel_x/y/z, rate_x/y/z
//
// One byte per cycle while full is low. After the trailer byte is accepted, a
// result passes the frame queue, one multiply stage and the result queue.
// Reset clears framing position, checksum state, the multiply stage and both queues.
// full rises only while the frame queue is full; a stalled result side
// first fills the result queue, then the frame queue.
module imu_frame_parser
	import imufp_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         rx_byte,
	input  logic               pop,
	output logic               empty,
	output logic signed [15:0] yaw,
	output logic signed [15:0] pitch,
	output logic signed [15:0] roll,
	output logic signed [2:0]  accel_x,
	output logic signed [2:0]  accel_y,
	output logic signed [2:0]  accel_z,
	output logic signed [11:0] rate_x,
	output logic signed [11:0] rate_y,
	output logic signed [11:0] rate_z
);

	logic    accept;
	logic    frame_push;
	frame_t  frame_in;
	frame_t  frame_out;
	logic    mid_empty;
	link_t   mid_link;
	logic    mid_pop;
	logic    res_full;
	logic    res_push;
	result_t res_in;
	result_t res_out;

	assign accept = push && !full;

	imufp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (rx_byte),
		.frame_push (frame_push),
		.frame      (frame_in)
	);

	imufp_fifo #(
		.WIDTH ($bits(frame_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_frame_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (frame_push),
		.wr_data (frame_in),
		.full    (full),
		.rd_en   (mid_pop),
		.rd_data (frame_out),
		.empty   (mid_empty)
	);

	assign mid_link.valid = !mid_empty;

	imufp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_link  (mid_link),
		.in_pop   (mid_pop),
		.frame    (frame_out),
		.out_full (res_full),
		.out_push (res_push),
		.result   (res_in)
	);

	imufp_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_result_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign yaw     = res_out.yaw;
	assign pitch   = res_out.pitch;
	assign roll    = res_out.roll;
	assign accel_x = res_out.accel_x;
	assign accel_y = res_out.accel_y;
	assign accel_z = res_out.accel_z;
	assign rate_x  = res_out.rate_x;
	assign rate_y  = res_out.rate_y;
	assign rate_z  = res_out.rate_z;

endmodule

@@ rtl/core/imufp_fifo.sv @@
module imufp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ rtl/core/imufp_front.sv @@
module imufp_front
	import imufp_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   accept,
	input  logic   [7:0] rx_byte,
	output logic   frame_push,
	output frame_t frame
);

	logic [5:0]           pos_q;
	logic [7:0]           sum_q;
	logic                 sum_ok_q;
	logic [7:0]           pay_q [PAY_COUNT];
	logic [PAY_IDX_W-1:0] pay_idx;

	assign pay_idx = PAY_IDX_W'(pos_q - PAY_FIRST);

	always_comb begin
		for (int j = 0; j < NUM_WORDS; j++) begin
			frame.words[j] = {pay_q[2*j], pay_q[2*j+1]};
		end
	end

	assign frame_push = accept && (pos_q >= POS_TAIL) && (rx_byte == TAIL_BYTE) && sum_ok_q;

	always_ff @(posedge clk) begin
		if (accept && (pos_q >= PAY_FIRST) && (pos_q <= PAY_LAST)) begin
			pay_q[pay_idx] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_HEAD0;
			sum_q    <= '0;
			sum_ok_q <= 1'b0;
		end else if (accept) begin
			if (pos_q == POS_HEAD0) begin
				if (rx_byte == HEAD0_BYTE) begin
					pos_q <= POS_HEAD1;
				end
			end else if (pos_q == POS_HEAD1) begin
				if (rx_byte == HEAD1_BYTE) begin
					pos_q <= pos_q + 6'd1;
					sum_q <= '0;
				end else begin
					pos_q <= POS_HEAD0;
				end
			end else if (pos_q <= POS_BODY_LAST) begin
				sum_q <= sum_q + rx_byte;
				pos_q <= pos_q + 6'd1;
			end else if (pos_q == POS_CHECK) begin
				sum_ok_q <= (rx_byte == sum_q);
				pos_q    <= POS_TAIL;
			end else if (rx_byte != TAIL_BYTE) begin
				pos_q <= POS_HEAD1;
			end else begin
				pos_q <= POS_HEAD0;
			end
		end
	end

endmodule

@@ rtl/core/imufp_back.sv @@
module imufp_back
	import imufp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  link_t   in_link,
	output logic    in_pop,
	input  frame_t  frame,
	input  logic    out_full,
	output logic    out_push,
	output result_t result
);

	logic                    v_s1;
	logic [15:0]             ang_s1  [3];
	logic [1:0]              acc_s1  [3];
	logic [RATE_X_W-1:0]     x_s1    [3];
	logic [RATE_Q_W-1:0]     qe_s1   [3];
	logic [RATE_X_W-1:0]     x_in    [3];
	logic [RATE_PROD_W-1:0]  prod_in [3];
	logic [RATE_Q_W-1:0]     q_fix   [3];
	logic [RATE_X_W-1:0]     rem     [3];
	logic                    adv;

	assign out_push = v_s1 && !out_full;
	assign adv      = !v_s1 || !out_full;
	assign in_pop   = in_link.valid && adv;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			x_in[j]    = {1'b0, frame.words[6+j], 2'b00} + RATE_X_W'(frame.words[6+j]);
			prod_in[j] = RATE_PROD_W'(x_in[j]) * RATE_PROD_W'(RATE_RECIP);
		end
	end

	always_ff @(posedge clk) begin
		if (in_pop) begin
			for (int j = 0; j < 3; j++) begin
				ang_s1[j] <= frame.words[j];
				acc_s1[j] <= frame.words[3+j][15:ACCEL_SHIFT];
				x_s1[j]   <= x_in[j];
				qe_s1[j]  <= prod_in[j][RATE_SHIFT +: RATE_Q_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_link.valid;
		end
	end

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			rem[j]   = x_s1[j] - RATE_X_W'(qe_s1[j]) * RATE_DEN;
			q_fix[j] = qe_s1[j] + RATE_Q_W'(rem[j] >= RATE_DEN);
		end
		result.yaw     = -ang_s1[0];
		result.pitch   = -ang_s1[1];
		result.roll    = -ang_s1[2];
		result.accel_x = -{1'b0, acc_s1[0]};
		result.accel_y = -{1'b0, acc_s1[1]};
		result.accel_z = -{1'b0, acc_s1[2]};
		result.rate_x  = -{1'b0, q_fix[0]};
		result.rate_y  = -{1'b0, q_fix[1]};
		result.rate_z  = -{1'b0, q_fix[2]};
	end

endmodule

@@ sim/tb_imu_frame_parser.sv @@
module tb_imu_frame_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import imufp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int BODY_LEN = 36;
	localparam int PACKET_LEN = 40;

	typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_TAIL} flaw_e;
	typedef enum int {POP_ALWAYS, POP_COIN, POP_SPARSE, POP_TOGGLE} pop_mode_e;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic pop = 1'b0;
	logic full;
	logic empty;
	logic signed [15:0] yaw;
	logic signed [15:0] pitch;
	logic signed [15:0] roll;
	logic signed [2:0] accel_x;
	logic signed [2:0] accel_y;
	logic signed [2:0] accel_z;
	logic signed [11:0] rate_x;
	logic signed [11:0] rate_y;
	logic signed [11:0] rate_z;

	// frame tracker state
	logic [5:0] frame_pos = POS_HEAD0;
	logic [7:0] body_sum = 8'h00;
	logic [7:0] frame_pay [PAY_COUNT];
	bit sum_ok = 1'b0;

	result_t decoded_q [$];
	result_t want;
	logic [7:0] body [BODY_LEN];

	int errors = 0;
	int cycles = 0;
	int frames_decoded = 0;
	int frame_bytes = 0;
	int burst_left = 0;
	int gap_max = 0;
	int hold_cycles = 0;
	int mode_left = 0;
	pop_mode_e pop_mode = POP_ALWAYS;

	imu_frame_parser i_dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("imu_frame_parser: mismatch");
			$finish;
		end
	end

	function automatic result_t decode_frame();
		logic [15:0] w [NUM_WORDS];
		result_t r;
		for (int k = 0; k < NUM_WORDS; k++)
			w[k] = {frame_pay[2*k], frame_pay[2*k+1]};
		r.yaw     = 16'(-int'(w[0]));
		r.pitch   = 16'(-int'(w[1]));
		r.roll    = 16'(-int'(w[2]));
		r.accel_x = 3'(-int'(w[3] >> ACCEL_SHIFT));
		r.accel_y = 3'(-int'(w[4] >> ACCEL_SHIFT));
		r.accel_z = 3'(-int'(w[5] >> ACCEL_SHIFT));
		r.rate_x  = 12'(-(int'(w[6]) * 5 / 164));
		r.rate_y  = 12'(-(int'(w[7]) * 5 / 164));
		r.rate_z  = 12'(-(int'(w[8]) * 5 / 164));
		return r;
	endfunction

	task automatic frame_track(input logic [7:0] b);
		if (frame_pos == POS_HEAD0) begin
			if (b == HEAD0_BYTE)
				frame_pos = POS_HEAD1;
		end else if (frame_pos == POS_HEAD1) begin
			if (b == HEAD1_BYTE) begin
				frame_pos = POS_HEAD1 + 6'd1;
				body_sum = 8'h00;
			end else begin
				frame_pos = POS_HEAD0;
			end
		end else if (frame_pos <= POS_BODY_LAST) begin
			body_sum = body_sum + b;
			if (frame_pos >= PAY_FIRST && frame_pos <= PAY_LAST)
				frame_pay[frame_pos - PAY_FIRST] = b;
			frame_pos = frame_pos + 6'd1;
		end else if (frame_pos == POS_CHECK) begin
			sum_ok = (b == body_sum);
			frame_pos = POS_TAIL;
		end else if (b != TAIL_BYTE) begin
			// resync on the second header byte
			frame_pos = POS_HEAD1;
		end else begin
			frame_pos = POS_HEAD0;
			if (sum_ok) begin
				decoded_q.push_back(decode_frame());
				frames_decoded++;
			end
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		frame_track(b);
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			4: return 16'h4000;
			5: return 16'h3FFF;
			6: return 16'hC000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic set_word(input int idx, input logic [15:0] v);
		body[1 + 2*idx] = v[15:8];
		body[2 + 2*idx] = v[7:0];
	endtask

	task automatic fill_body(input bit extremes);
		for (int k = 0; k < BODY_LEN; k++)
			body[k] = 8'($urandom);
		if (extremes)
			for (int w = 0; w < NUM_WORDS; w++)
				if ($urandom_range(0, 1))
					set_word(w, pick_word());
	endtask

	task automatic send_packet(input flaw_e flaw, input bit headless, input int upto);
		logic [7:0] chk;
		logic [7:0] pkt [PACKET_LEN];
		chk = 8'h00;
		for (int k = 0; k < BODY_LEN; k++) begin
			chk = chk + body[k];
			pkt[k + 2] = body[k];
		end
		pkt[0] = HEAD0_BYTE;
		pkt[1] = HEAD1_BYTE;
		pkt[38] = (flaw == FLAW_SUM) ? chk + 8'($urandom_range(1, 255)) : chk;
		pkt[39] = TAIL_BYTE;
		if (flaw == FLAW_TAIL)
			while (pkt[39] == TAIL_BYTE)
				pkt[39] = 8'($urandom);
		for (int k = headless ? 1 : 0; k < upto; k++) begin
			send_byte(pkt[k]);
			frame_bytes++;
		end
	endtask

	task automatic check_field(input string name, input int exp_val, input int got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (decoded_q.size() == 0) begin
				$error("result with no decoded frame pending");
				errors++;
			end else begin
				want = decoded_q.pop_front();
				check_field("yaw", want.yaw, yaw);
				check_field("pitch", want.pitch, pitch);
				check_field("roll", want.roll, roll);
				check_field("accel_x", want.accel_x, accel_x);
				check_field("accel_y", want.accel_y, accel_y);
				check_field("accel_z", want.accel_z, accel_z);
				check_field("rate_x", want.rate_x, rate_x);
				check_field("rate_y", want.rate_y, rate_y);
				check_field("rate_z", want.rate_z, rate_z);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (hold_cycles > 0) begin
			pop <= 1'b0;
			hold_cycles--;
		end else begin
			if (mode_left == 0) begin
				pop_mode = pop_mode_e'($urandom_range(0, 3));
				mode_left = $urandom_range(8, 96);
			end else begin
				mode_left--;
			end
			case (pop_mode)
				POP_ALWAYS: pop <= 1'b1;
				POP_COIN:   pop <= 1'($urandom_range(0, 1));
				POP_SPARSE: pop <= ($urandom_range(0, 3) == 0);
				default:    pop <= ~pop;
			endcase
		end
	end

	task automatic test_extremes();
		gap_max = 0;
		for (int k = 0; k < BODY_LEN; k++)
			body[k] = 8'h00;
		send_packet(FLAW_NONE, 1'b0, PACKET_LEN);
		for (int k = 0; k < BODY_LEN; k++)
			body[k] = 8'hFF;
		send_packet(FLAW_NONE, 1'b0, PACKET_LEN);
		set_word(0, 16'h8000);
		set_word(1, 16'h7FFF);
		set_word(2, 16'h0001);
		set_word(3, 16'h3FFF);
		set_word(4, 16'h4000);
		set_word(5, 16'hC000);
		set_word(6, 16'd32);
		set_word(7, 16'd33);
		set_word(8, 16'hFFFE);
		send_packet(FLAW_NONE, 1'b0, PACKET_LEN);
		wait_idle();
	endtask

	task automatic test_bad_header();
		gap_max = 3;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(HEAD1_BYTE);
		send_byte(HEAD0_BYTE);
		send_byte(HEAD0_BYTE);
		send_byte(HEAD1_BYTE);
		fill_body(1'b1);
		send_packet(FLAW_NONE, 1'b0, PACKET_LEN);
		wait_idle();
	endtask

	task automatic test_bad_tail();
		gap_max = 2;
		fill_body(1'b1);
		send_packet(FLAW_TAIL, 1'b0, PACKET_LEN);
		fill_body(1'b1);
		send_packet(FLAW_NONE, 1'b1, PACKET_LEN);
		wait_idle();
	endtask

	task automatic test_bad_sum();
		gap_max = 2;
		fill_body(1'b0);
		send_packet(FLAW_SUM, 1'b0, PACKET_LEN);
		fill_body(1'b0);
		send_packet(FLAW_NONE, 1'b0, PACKET_LEN);
		wait_idle();
	endtask

	task automatic test_backpressure();
		gap_max = 0;
		hold_cycles = 900;
		repeat (8) begin
			fill_body(1'b1);
			send_packet(FLAW_NONE, 1'b0, PACKET_LEN);
		end
		// hold requests until every decoded frame has drained
		wait_idle();
	endtask

	task automatic test_random();
		int pick;
		frame_bytes = 0;
		while (frame_bytes < 800) begin
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			pick = $urandom_range(0, 99);
			fill_body($urandom_range(0, 1));
			if (pick < 65) begin
				send_packet(FLAW_NONE, 1'b0, PACKET_LEN);
			end else if (pick < 75) begin
				send_packet(FLAW_SUM, 1'b0, PACKET_LEN);
			end else if (pick < 87) begin
				send_packet(FLAW_TAIL, 1'b0, PACKET_LEN);
				fill_body(1'b1);
				send_packet(($urandom_range(0, 3) == 0) ? FLAW_SUM : FLAW_NONE,
					$urandom_range(0, 3) != 0, PACKET_LEN);
			end else if (pick < 93) begin
				send_packet(FLAW_NONE, 1'b0, $urandom_range(3, 38));
			end else begin
				repeat ($urandom_range(1, 6)) begin
					case ($urandom_range(0, 3))
						0: send_byte(HEAD0_BYTE);
						1: send_byte(HEAD1_BYTE);
						default: send_byte(8'($urandom));
					endcase
				end
			end
		end
		wait_idle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_bad_header();
		test_bad_tail();
		test_bad_sum();
		test_backpressure();
		test_random();
		if (errors == 0)
			$display("imu_frame_parser: match");
		else
			$display("imu_frame_parser: mismatch");
		$finish;
	end

endmodule
